### rtl/sha256_hash_engine_defines.svh
// Assertion macros shared by the SHA-256 engine RTL.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sha256_pkg.sv
// Types, constants and bit functions of the SHA-256 engine.
package sha256_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic update;
  } round_ctl_t;

  typedef struct packed {
    logic wr;
    logic shift;
  } sched_ctl_t;

  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [5:0] RND_LAST   = 6'd63;
  localparam logic [2:0] IDX_LAST   = 3'd7;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

### rtl/sha256_in_if.sv
// Message word channel: valid/ready with data, byte count and end mark.
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        end_of_message;

  modport source (output valid, data_word, byte_count, end_of_message, input ready);
  modport sink   (input valid, data_word, byte_count, end_of_message, output ready);
endinterface

### rtl/sha256_out_if.sv
// Digest word channel: valid/ready with digest word, index and last flag.
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha256_round.sv
// Shared round unit: working variables, hash state and one round per cycle.
module sha256_round (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256_pkg::round_ctl_t ctl_i,
  input  sha256_pkg::word_t      w_i,
  input  logic [5:0]             rnd_i,
  input  logic [2:0]             rd_idx_i,
  output sha256_pkg::word_t      rd_word_o
);
  import sha256_pkg::*;

  word_t hash_q [8];
  word_t work_q [8];
  word_t ch, maj, t1, t2;

  always_comb begin
    ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1  = work_q[7] + big_sigma1(work_q[4]) + ch + ROUND_K[rnd_i] + w_i;
    t2  = big_sigma0(work_q[0]) + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= H_INIT[i];
    end else if (ctl_i.init) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= H_INIT[i];
    end else if (ctl_i.update) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + work_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      for (int i = 0; i < 8; i++) work_q[i] <= hash_q[i];
    end else if (ctl_i.step) begin
      work_q[0] <= t1 + t2;
      work_q[1] <= work_q[0];
      work_q[2] <= work_q[1];
      work_q[3] <= work_q[2];
      work_q[4] <= work_q[3] + t1;
      work_q[5] <= work_q[4];
      work_q[6] <= work_q[5];
      work_q[7] <= work_q[6];
    end
  end

  assign rd_word_o = hash_q[rd_idx_i];

endmodule

### rtl/sha256_sched.sv
// Block buffer and rolling 16-word message schedule in one register window.
module sha256_sched (
  input  logic                   clk_i,
  input  sha256_pkg::sched_ctl_t ctl_i,
  input  logic [5:0]             fill_i,
  input  logic [7:0]             byte_i,
  output sha256_pkg::word_t      w_o
);
  import sha256_pkg::*;

  word_t      win_q [16];
  word_t      w_next;
  logic [1:0] lane;

  assign lane   = ~fill_i[1:0];
  assign w_next = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      win_q[fill_i[5:2]][{lane, 3'b000} +: 8] <= byte_i;
    end else if (ctl_i.shift) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= w_next;
    end
  end

  assign w_o = win_q[0];

endmodule

### rtl/sha256_hash_engine.sv
// SHA-256 engine top level: byte sequencer, padding, and digest output.
// Each accepted word is taken in S_IDLE and its valid bytes are then pushed into
// the block buffer from S_DATA; every completed 64-byte block then runs 64 rounds
// through the single shared round unit, one round per clock, and one hash update
// step. The final word also pushes 9 to 72 padding and length bytes, one byte per
// cycle while no block is being compressed, with one or two block compressions,
// and then emits eight digest beats through an output register; the input side
// takes a new word once the digest is queued.
`include "sha256_hash_engine_defines.svh"

module sha256_hash_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  sha256_in_if.sink           msg_i,
  sha256_out_if.source        dig_o
);
  import sha256_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DATA   = 8'b0000_0010,
    S_PAD    = 8'b0000_0100,
    S_ZERO   = 8'b0000_1000,
    S_LEN    = 8'b0001_0000,
    S_ROUND  = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d, ret_q, ret_d, src_next;
  logic [5:0]  fill_q, fill_d, fill_inc;
  logic [63:0] bitlen_q, bitlen_d;
  logic [31:0] data_q, data_d;
  logic [2:0]  cnt_q, cnt_d, cnt_in;
  logic        last_q, last_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        push;
  logic [7:0]  push_byte;

  logic        out_valid_q, out_valid_d;
  word_t       out_word_q, out_word_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        out_last_q, out_last_d;

  round_ctl_t  rctl;
  sched_ctl_t  sctl;
  word_t       w_cur, hash_word;
  logic        accept;

  assign msg_i.ready = (state_q == S_IDLE);
  assign accept      = msg_i.valid & msg_i.ready;
  assign cnt_in      = (msg_i.byte_count > WORD_BYTES) ? WORD_BYTES : msg_i.byte_count;
  assign fill_inc    = fill_q + 6'd1;

  always_comb begin
    push      = 1'b0;
    push_byte = 8'h00;
    src_next  = S_IDLE;
    case (state_q)
      S_DATA: begin
        push      = 1'b1;
        push_byte = data_q[31:24];
        src_next  = (cnt_q == 3'd1) ? (last_q ? S_PAD : S_IDLE) : S_DATA;
      end
      S_PAD: begin
        push      = 1'b1;
        push_byte = PAD_BYTE;
        src_next  = (fill_inc == FILL_LEN) ? S_LEN : S_ZERO;
      end
      S_ZERO: begin
        push      = 1'b1;
        push_byte = 8'h00;
        src_next  = (fill_inc == FILL_LEN) ? S_LEN : S_ZERO;
      end
      S_LEN: begin
        push      = 1'b1;
        push_byte = bitlen_q[{~idx_q, 3'b000} +: 8];
        src_next  = (idx_q == IDX_LAST) ? S_OUT : S_LEN;
      end
      default: begin
        push      = 1'b0;
        push_byte = 8'h00;
        src_next  = S_IDLE;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fill_d      = fill_q;
    bitlen_d    = bitlen_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    rctl        = '0;
    sctl        = '0;

    if (out_valid_q && dig_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (push) begin
      sctl.wr = 1'b1;
      fill_d  = fill_inc;
      if (fill_q == FILL_LAST) begin
        rctl.load = 1'b1;
        rnd_d     = '0;
        ret_d     = src_next;
        state_d   = S_ROUND;
      end else begin
        state_d = src_next;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          bitlen_d = bitlen_q + {58'd0, cnt_in, 3'b000};
          data_d   = msg_i.data_word;
          cnt_d    = cnt_in;
          last_d   = msg_i.end_of_message;
          if (cnt_in != 3'd0) begin
            state_d = S_DATA;
          end else if (msg_i.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end
      S_DATA: begin
        data_d = {data_q[23:0], 8'h00};
        cnt_d  = cnt_q - 3'd1;
      end
      S_PAD, S_ZERO: begin
        idx_d = '0;
      end
      S_LEN: begin
        idx_d = idx_q + 3'd1;
      end
      S_ROUND: begin
        rctl.step  = 1'b1;
        sctl.shift = 1'b1;
        rnd_d      = rnd_q + 6'd1;
        if (rnd_q == RND_LAST) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        rctl.update = 1'b1;
        state_d     = ret_q;
      end
      S_OUT: begin
        if (!out_valid_q || dig_o.ready) begin
          out_valid_d = 1'b1;
          out_word_d  = hash_word;
          out_idx_d   = idx_q;
          out_last_d  = (idx_q == IDX_LAST);
          idx_d       = idx_q + 3'd1;
          if (idx_q == IDX_LAST) begin
            rctl.init = 1'b1;
            bitlen_d  = '0;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      fill_q      <= '0;
      bitlen_q    <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      rnd_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fill_q      <= fill_d;
      bitlen_q    <= bitlen_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      rnd_q       <= rnd_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctl_i  (sctl),
    .fill_i (fill_q),
    .byte_i (push_byte),
    .w_o    (w_cur)
  );

  sha256_round u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (rctl),
    .w_i       (w_cur),
    .rnd_i     (rnd_q),
    .rd_idx_i  (idx_q),
    .rd_word_o (hash_word)
  );

  assign dig_o.valid       = out_valid_q;
  assign dig_o.digest_word = out_word_q;
  assign dig_o.word_index  = out_idx_q;
  assign dig_o.last_word   = out_last_q;

  `SHA_ASSERT_NEXT(a_round_end, (state_q == S_ROUND) && (rnd_q == RND_LAST), state_q == S_UPDATE, "round loop did not end in hash update")
  `SHA_ASSERT_NOW(a_len_fill, state_q == S_LEN, fill_q[5:3] == 3'd7, "length bytes outside last block slots")
  `SHA_ASSERT_NOW(a_out_empty, state_q == S_OUT, fill_q == 6'd0, "digest output with partial block held")

endmodule
